// File: hdl/scfa_pkg.sv
// Shared types, constants and the size-class function of the free-list allocator.
// Used by scfa_front, scfa_back and size_class_free_list_allocator_unit.
`default_nettype none
package scfa_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned NUM_CLASSES_DEF  = 11;
  localparam int unsigned HEADER_BYTES_DEF = 32;
  localparam int unsigned MIN_REQUEST_DEF  = 16;
  localparam int unsigned GRANULE_BYTES    = 8;
  localparam int unsigned GRAN_SH          = $clog2(GRANULE_BYTES);

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned MAX_OW  = 20;
  localparam int unsigned SZ_W    = 21;
  localparam int unsigned CLS_W   = 4;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              zero;
    logic              skip;
    logic [CLS_W-1:0]  cls;
    logic [MAX_OW-1:0] ofs;
  } cmd_t;

  function automatic logic [CLS_W-1:0] class_of(input logic [SZ_W-1:0] size,
                                                 input int unsigned min_req,
                                                 input int unsigned nc);
    logic [SZ_W-1:0] v;
    int unsigned     lg;
    logic [CLS_W-1:0] res;
    v   = size - SZ_W'(1);
    lg  = 0;
    res = '0;
    for (int b = 0; b < SZ_W; b++) begin
      if (v[b]) lg = b;
    end
    if (size < SZ_W'(min_req) || size < SZ_W'(2) || lg < 3) begin
      res = '0;
    end else if (lg - 3 >= nc) begin
      res = CLS_W'(nc - 1);
    end else begin
      res = CLS_W'(lg - 3);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: hdl/scfa_front.sv
// Front end: takes commands, computes size class and free target, queues two deep.
// Depends on scfa_pkg.
`default_nettype none
module scfa_front #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned NUM_CLASSES  = 11,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned MIN_REQUEST  = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           operation_i,
  input  wire logic [scfa_pkg::FIELD_W-1:0]   request_size_i,
  input  wire logic [scfa_pkg::FIELD_W-1:0]   user_offset_i,
  input  wire logic                           clearing_i,
  output logic                                cmd_valid_o,
  output scfa_pkg::cmd_t                      cmd_o,
  input  wire logic                           cmd_pop_i
);
  import scfa_pkg::*;

  cmd_t        q_mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  cmd_t        cmd_new;
  logic [SZ_W-1:0] req_x, uofs_x, free_ofs;

  assign busy   = (cnt_q == 2'd2) || clearing_i;
  assign accept = start && !busy;

  always_comb begin
    req_x    = SZ_W'(request_size_i) + SZ_W'(HEADER_BYTES);
    uofs_x   = SZ_W'(user_offset_i);
    free_ofs = uofs_x - SZ_W'(HEADER_BYTES);
    cmd_new.op   = op_e'(operation_i);
    cmd_new.zero = (request_size_i == '0);
    cmd_new.skip = (user_offset_i == '0) || (uofs_x < SZ_W'(HEADER_BYTES)) ||
                   (free_ofs >= SZ_W'(HEAP_BYTES));
    cmd_new.cls  = class_of(req_x, MIN_REQUEST, NUM_CLASSES);
    cmd_new.ofs  = free_ofs[MAX_OW-1:0];
  end

  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = accept    ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(accept) - 2'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) q_mem_q[wr_ptr_q] <= cmd_new;
  end

endmodule
`default_nettype wire

// File: hdl/scfa_back.sv
// Back end: class heads, link and size memories, pop/split/push sequencer.
// Depends on scfa_pkg; fed by scfa_front.
`default_nettype none
module scfa_back #(
  parameter int unsigned HEAP_BYTES   = 65536,
  parameter int unsigned NUM_CLASSES  = 11,
  parameter int unsigned HEADER_BYTES = 32,
  parameter int unsigned MIN_REQUEST  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire scfa_pkg::cmd_t               cmd_i,
  output logic                              cmd_pop_o,
  output logic                              clearing_o,
  output logic                              done_o,
  output logic [scfa_pkg::FIELD_W-1:0]      granted_offset_o,
  output logic [1:0]                        status_o
);
  import scfa_pkg::*;

  localparam int unsigned OW    = $clog2(HEAP_BYTES);
  localparam int unsigned IW    = OW - GRAN_SH;
  localparam int unsigned DEPTH = HEAP_BYTES >> GRAN_SH;
  localparam int unsigned CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned WW    = OW + 2;

  typedef enum logic [5:0] {
    S_CLR   = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_SPLIT = 6'b001000,
    S_FIX   = 6'b010000,
    S_FREE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic          head_vld_q [NUM_CLASSES];
  logic [OW-1:0] head_ofs_q [NUM_CLASSES];

  logic [OW:0]   link_mem [DEPTH];
  logic [OW-1:0] size_mem [DEPTH];
  logic [OW:0]   link_rd_q;
  logic [OW-1:0] size_rd_q;

  logic [CW-1:0] cls_q, hit_q;
  logic [OW-1:0] ofs_q, cur_q;
  logic [IW-1:0] idx_q;
  logic          any_q, link0_q;
  logic [IW:0]   clr_q;

  logic          done_q;
  logic [FIELD_W-1:0] gofs_q;
  status_e       status_q;

  logic          found;
  logic [CW-1:0] hit;
  logic [IW-1:0] rd_idx;
  logic [OW-1:0] half;
  logic [WW-1:0] nofs;
  logic [WW-1:0] cur_w;
  logic          go, stop;
  logic [CW-1:0] c_split, c_free;
  logic          size_we, link_we;
  logic [IW-1:0] size_wa, link_wa;
  logic [OW-1:0] size_wd;
  logic [OW:0]   link_wd;
  logic [OW:0]   link_eff;

  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (!found && (CW'(i) >= CW'(cmd_i.cls)) && head_vld_q[i]) begin
        found = 1'b1;
        hit   = CW'(i);
      end
    end
  end

  always_comb begin
    half    = cur_q >> 1;
    nofs    = WW'(ofs_q) + WW'(half) + WW'(HEADER_BYTES);
    cur_w   = WW'(cur_q);
    go      = (cur_w >> (32'(cls_q) + 5)) != '0;
    stop    = !go || (half <= OW'(HEADER_BYTES)) || (nofs >= WW'(HEAP_BYTES));
    c_split = CW'(class_of(SZ_W'(half), MIN_REQUEST, NUM_CLASSES));
    c_free  = CW'(class_of(SZ_W'(size_rd_q), MIN_REQUEST, NUM_CLASSES));
    link_eff = (idx_q == '0 && !link0_q) ? '0 : link_rd_q;
    if (state_q == S_IDLE) begin
      rd_idx = (cmd_i.op == OP_ALLOC) ? IW'(head_ofs_q[hit] >> GRAN_SH)
                                      : IW'(cmd_i.ofs >> GRAN_SH);
    end else begin
      rd_idx = idx_q;
    end
  end

  always_comb begin
    size_we = 1'b0;
    size_wa = idx_q;
    size_wd = cur_q - OW'(HEADER_BYTES);
    link_we = 1'b0;
    link_wa = idx_q;
    link_wd = {head_vld_q[c_free], head_ofs_q[c_free]};
    case (state_q)
      S_CLR: begin
        size_we = 1'b1;
        size_wa = clr_q[IW-1:0];
        size_wd = (clr_q == '0) ? OW'(HEAP_BYTES - HEADER_BYTES) : '0;
      end
      S_SPLIT: begin
        if (!stop) begin
          size_we = 1'b1;
          size_wa = IW'(nofs >> GRAN_SH);
          size_wd = half - OW'(HEADER_BYTES);
          link_we = 1'b1;
          link_wa = IW'(nofs >> GRAN_SH);
          link_wd = {head_vld_q[c_split], head_ofs_q[c_split]};
        end
      end
      S_FIX: size_we = 1'b1;
      S_FREE: link_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (size_we) size_mem[size_wa] <= size_wd;
    size_rd_q <= size_mem[rd_idx];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[rd_idx];
  end

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    case (state_q)
      S_CLR:   if (clr_q == (IW+1)'(DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.op == OP_ALLOC) begin
            if (!cmd_i.zero && found) state_d = S_RD;
          end else if (!cmd_i.skip) begin
            state_d = S_FREE;
          end
        end
      end
      S_RD:    state_d = (hit_q > cls_q) ? S_SPLIT : S_IDLE;
      S_SPLIT: if (stop) state_d = any_q ? S_FIX : S_IDLE;
      S_FIX:   state_d = S_IDLE;
      S_FREE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      link0_q  <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      gofs_q   <= '0;
      cls_q    <= '0;
      hit_q    <= '0;
      ofs_q    <= '0;
      idx_q    <= '0;
      cur_q    <= '0;
      any_q    <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_vld_q[i] <= (i == NUM_CLASSES - 1);
        head_ofs_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (link_we && link_wa == '0) link0_q <= 1'b1;
      case (state_q)
        S_CLR: clr_q <= clr_q + 1'b1;
        S_IDLE: begin
          if (cmd_valid_i) begin
            cls_q <= CW'(cmd_i.cls);
            hit_q <= hit;
            if (cmd_i.op == OP_ALLOC) begin
              ofs_q <= head_ofs_q[hit];
              idx_q <= IW'(head_ofs_q[hit] >> GRAN_SH);
              if (cmd_i.zero) begin
                done_q <= 1'b1; status_q <= ST_ZERO; gofs_q <= '0;
              end else if (!found) begin
                done_q <= 1'b1; status_q <= ST_NOSPACE; gofs_q <= '0;
              end
            end else begin
              ofs_q <= OW'(cmd_i.ofs);
              idx_q <= IW'(cmd_i.ofs >> GRAN_SH);
              if (cmd_i.skip) begin
                done_q <= 1'b1; status_q <= ST_OK; gofs_q <= '0;
              end
            end
          end
        end
        S_RD: begin
          head_vld_q[hit_q] <= link_eff[OW];
          head_ofs_q[hit_q] <= link_eff[OW-1:0];
          cur_q <= size_rd_q;
          any_q <= 1'b0;
          if (!(hit_q > cls_q)) begin
            done_q <= 1'b1; status_q <= ST_OK;
            gofs_q <= FIELD_W'(ofs_q + OW'(HEADER_BYTES));
          end
        end
        S_SPLIT: begin
          if (stop) begin
            if (!any_q) begin
              done_q <= 1'b1; status_q <= ST_OK;
              gofs_q <= FIELD_W'(ofs_q + OW'(HEADER_BYTES));
            end
          end else begin
            head_vld_q[c_split] <= 1'b1;
            head_ofs_q[c_split] <= OW'(nofs);
            cur_q <= half;
            any_q <= 1'b1;
          end
        end
        S_FIX: begin
          done_q <= 1'b1; status_q <= ST_OK;
          gofs_q <= FIELD_W'(ofs_q + OW'(HEADER_BYTES));
        end
        S_FREE: begin
          head_vld_q[c_free] <= 1'b1;
          head_ofs_q[c_free] <= ofs_q;
          done_q <= 1'b1; status_q <= ST_OK; gofs_q <= '0;
        end
        default: ;
      endcase
    end
  end

  assign clearing_o       = (state_q == S_CLR);
  assign done_o           = done_q;
  assign granted_offset_o = gofs_q;
  assign status_o         = status_q;

endmodule
`default_nettype wire

// File: hdl/size_class_free_list_allocator_unit.sv
// Top level of the power-of-two size-class free-list allocator.
// Instantiates scfa_front and scfa_back; depends on scfa_pkg.
//
//  beat      handshake           payload
//  command   start / busy        operation_i, request_size_i, user_offset_i
//  result    done_o (strobe)     granted_offset_o, status_o
//
// A free pushes the block onto its class list; a failed or null command is answered
// from idle. An allocate pops a class head and, if that class is larger, halves the
// block once per split step, then fixes the popped size if any halving was done;
// the split sequencer works on the size/link memory port.
// After reset busy stays high while the size memory is cleared.
// A two-deep command queue lets start be taken while the back end works.
// Results cannot be stalled; each is on the ports for one cycle.
`default_nettype none
module size_class_free_list_allocator_unit #(
  parameter int unsigned HEAP_BYTES   = scfa_pkg::HEAP_BYTES_DEF,
  parameter int unsigned NUM_CLASSES  = scfa_pkg::NUM_CLASSES_DEF,
  parameter int unsigned HEADER_BYTES = scfa_pkg::HEADER_BYTES_DEF,
  parameter int unsigned MIN_REQUEST  = scfa_pkg::MIN_REQUEST_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         operation_i,
  input  wire logic [scfa_pkg::FIELD_W-1:0] request_size_i,
  input  wire logic [scfa_pkg::FIELD_W-1:0] user_offset_i,
  output logic                              done_o,
  output logic [scfa_pkg::FIELD_W-1:0]      granted_offset_o,
  output logic [1:0]                        status_o
);
  import scfa_pkg::*;

  logic cmd_valid, cmd_pop, clearing;
  cmd_t cmd;

  scfa_front #(
    .HEAP_BYTES(HEAP_BYTES), .NUM_CLASSES(NUM_CLASSES),
    .HEADER_BYTES(HEADER_BYTES), .MIN_REQUEST(MIN_REQUEST)
  ) u_front (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .request_size_i, .user_offset_i,
    .clearing_i(clearing), .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  scfa_back #(
    .HEAP_BYTES(HEAP_BYTES), .NUM_CLASSES(NUM_CLASSES),
    .HEADER_BYTES(HEADER_BYTES), .MIN_REQUEST(MIN_REQUEST)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .clearing_o(clearing), .done_o, .granted_offset_o, .status_o
  );

endmodule
`default_nettype wire

// File: test/size_class_free_list_allocator_unit_tb.sv
// Testbench for size_class_free_list_allocator_unit: directed and random allocate/free beats,
// each result checked against an in-bench allocator model. Depends on scfa_pkg.
module size_class_free_list_allocator_unit_tb;
  import scfa_pkg::*;

  localparam int unsigned HEAP   = 65536;
  localparam int unsigned NCLS   = 11;
  localparam int unsigned HDR    = 32;
  localparam int unsigned MINREQ = 16;
  localparam int unsigned GRAN   = 8;
  localparam int unsigned DEPTH  = HEAP / GRAN;
  localparam int unsigned LIMIT  = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        operation_i = 1'b0;
  logic [15:0] request_size_i = '0;
  logic [15:0] user_offset_i = '0;
  logic        done_o;
  logic [15:0] granted_offset_o;
  logic [1:0]  status_o;

  // bit 16 flags a valid stack entry
  logic [16:0] head_mdl [NCLS];
  logic [16:0] link_mdl [DEPTH];
  logic [15:0] size_mdl [DEPTH];

  logic [15:0] exp_grant_q [$];
  status_e     exp_status_q [$];
  logic [15:0] live_q [$];
  status_e     last_status;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;

  size_class_free_list_allocator_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .operation_i(operation_i), .request_size_i(request_size_i),
    .user_offset_i(user_offset_i), .done_o(done_o),
    .granted_offset_o(granted_offset_o), .status_o(status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    err_cnt++;
  endtask

  function automatic int unsigned bucket_of(input int unsigned sz);
    int unsigned v, lg;
    if (sz < MINREQ || sz < 2) return 0;
    v = sz - 1;
    lg = 0;
    while (v > 1) begin
      v >>= 1;
      lg++;
    end
    if (lg < 3) return 0;
    if (lg - 3 >= NCLS) return NCLS - 1;
    return lg - 3;
  endfunction

  function automatic void push_free(input int unsigned cls, input int unsigned ofs,
                                    input int unsigned idx);
    link_mdl[idx] = head_mdl[cls];
    head_mdl[cls] = {1'b1, ofs[15:0]};
  endfunction

  function automatic void reset_heap_model();
    for (int i = 0; i < NCLS; i++) head_mdl[i] = '0;
    for (int i = 0; i < DEPTH; i++) begin
      link_mdl[i] = '0;
      size_mdl[i] = '0;
    end
    size_mdl[0] = 16'(HEAP - HDR);
    head_mdl[NCLS-1] = {1'b1, 16'h0};
  endfunction

  function automatic void predict_heap_result(input op_e op, input logic [15:0] req,
                                              input logic [15:0] uofs);
    int unsigned cls, ofs, idx, cur, tgt, half, nofs, nidx;
    logic [15:0] grant;
    status_e     st;
    bit          found;
    grant = '0;
    st = ST_OK;
    if (op == OP_ALLOC) begin
      if (req == 0) begin
        st = ST_ZERO;
      end else begin
        cls = bucket_of(req + HDR);
        found = 0;
        for (int i = cls; i < NCLS && !found; i++) begin
          if (head_mdl[i][16]) begin
            found = 1;
            ofs = head_mdl[i][15:0];
            idx = (ofs / GRAN) % DEPTH;
            head_mdl[i] = link_mdl[idx];
            if (i > cls) begin
              cur = size_mdl[idx];
              tgt = 1 << (cls + 4);
              while (cur >= tgt * 2) begin
                half = cur / 2;
                nofs = ofs + half + HDR;
                nidx = nofs / GRAN;
                if (half <= HDR || nidx >= DEPTH) break;
                size_mdl[nidx] = 16'(half - HDR);
                size_mdl[idx] = 16'(half - HDR);
                push_free(bucket_of(half), nofs, nidx);
                cur = half;
              end
            end
            grant = 16'(ofs + HDR);
            live_q.push_back(grant);
          end
        end
        if (!found) st = ST_NOSPACE;
      end
    end else if (uofs >= HDR) begin
      ofs = uofs - HDR;
      idx = ofs / GRAN;
      if (idx < DEPTH) push_free(bucket_of(size_mdl[idx]), ofs, idx);
    end
    last_status = st;
    exp_grant_q.push_back(grant);
    exp_status_q.push_back(st);
  endfunction

  task automatic send_beat(input op_e op, input logic [15:0] req, input logic [15:0] uofs);
    @(negedge clk_i);
    start = 1'b1;
    operation_i = op;
    request_size_i = req;
    user_offset_i = uofs;
    do @(posedge clk_i); while (busy);
    predict_heap_result(op, req, uofs);
  endtask

  task automatic idle_gap(input bit quiet);
    int unsigned n;
    if (quiet) return;
    n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    if (n == 0) return;
    @(negedge clk_i);
    start = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  task automatic drain_results();
    int unsigned w;
    @(negedge clk_i);
    start = 1'b0;
    w = 0;
    while (exp_status_q.size() != 0 && w < 2000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (20) @(posedge clk_i);
  endtask

  task automatic free_live(input int unsigned k);
    logic [15:0] o;
    o = live_q[k];
    live_q.delete(k);
    send_beat(OP_FREE, 16'($urandom), o);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (exp_status_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        if (granted_offset_o !== exp_grant_q[0])
          report($sformatf("granted_offset %h expected %h", granted_offset_o, exp_grant_q[0]));
        if (status_o !== exp_status_q[0])
          report($sformatf("status %0d expected %0d", status_o, exp_status_q[0]));
        void'(exp_grant_q.pop_front());
        void'(exp_status_q.pop_front());
      end
    end
  end

  task automatic test_extremes();
    send_beat(OP_ALLOC, 16'd0, 16'hffff);
    send_beat(OP_ALLOC, 16'd1, 16'h0);
    send_beat(OP_ALLOC, 16'hffff, 16'h0);
    send_beat(OP_ALLOC, 16'd40, 16'h0);
    send_beat(OP_ALLOC, 16'd3000, 16'h0);
    idle_gap(0);
    send_beat(OP_ALLOC, 16'd0, 16'h0);
    while (live_q.size() != 0) free_live(0);
  endtask

  task automatic test_odd_frees();
    send_beat(OP_FREE, 16'hffff, 16'd0);
    send_beat(OP_FREE, 16'd0, 16'd16);
    send_beat(OP_FREE, 16'd0, 16'd31);
    send_beat(OP_FREE, 16'd0, 16'hffff);
    send_beat(OP_FREE, 16'd0, 16'd4104);
    send_beat(OP_ALLOC, 16'd100, 16'h0);
    send_beat(OP_FREE, 16'd0, live_q[0]);
    send_beat(OP_FREE, 16'd0, live_q[0]);
    live_q.delete();
  endtask

  task automatic test_exhaustion();
    int unsigned n;
    n = 0;
    do begin
      send_beat(OP_ALLOC, 16'd8000, 16'h0);
      n++;
    end while (last_status != ST_NOSPACE && n < 30);
    send_beat(OP_ALLOC, 16'hffff, 16'h0);
    drain_results();
    while (live_q.size() != 0) free_live($urandom_range(0, live_q.size() - 1));
  endtask

  task automatic test_random(input int unsigned items);
    int unsigned r;
    bit quiet;
    quiet = 0;
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 100 == 0) quiet = $urandom_range(0, 3) == 0;
      if (i == items / 2) drain_results();
      r = $urandom_range(0, 99);
      if (r < 50 || (r < 90 && live_q.size() == 0)) begin
        send_beat(OP_ALLOC, ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                  16'($urandom_range(1, 300)), 16'($urandom));
      end else if (r < 90) begin
        free_live($urandom_range(0, live_q.size() - 1));
      end else if (r < 95) begin
        send_beat(OP_FREE, 16'($urandom), 16'($urandom));
      end else begin
        send_beat(op_e'(r[0]), 16'd0, 16'($urandom_range(0, 40)));
      end
      idle_gap(quiet);
    end
  endtask

  initial begin
    reset_heap_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_odd_frees();
    test_exhaustion();
    test_random(1400);
    drain_results();
    if (err_cnt == 0 && exp_status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/scfa_pkg.sv
hdl/scfa_front.sv
hdl/scfa_back.sv
hdl/size_class_free_list_allocator_unit.sv
test/size_class_free_list_allocator_unit_tb.sv
